// File: hw/rtl/pmdq_pkg.sv
// ----------------------------------------------------------------------------
// pmdq_pkg: shared types and helpers for the priority message dispatch queue
// Queue geometry, message layout, status and command codes, index helpers.
// ----------------------------------------------------------------------------
package pmdq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TASK_SLOTS  = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [15:0] param;
    logic [7:0]  sig;
    logic [2:0]  dst;
    logic [3:0]  src;
  } msg_t;

  localparam int MSG_W = $bits(msg_t);

  localparam logic CMD_POST     = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_UNKNOWN    = 3'd1;
  localparam logic [2:0] STAT_FULL       = 3'd2;
  localparam logic [2:0] STAT_EMPTY      = 3'd3;
  localparam logic [2:0] STAT_NO_HANDLER = 3'd4;

  localparam logic [1:0] REG_PRESENT  = 2'd0;
  localparam logic [1:0] REG_HANDLER  = 2'd1;
  localparam logic [1:0] REG_PRIORITY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  function automatic logic task_bit(input logic [7:0] mask, input logic [2:0] id);
    return (32'(id) < TASK_SLOTS) && mask[id];
  endfunction

  function automatic logic [7:0] task_prio(input logic [63:0] prios, input logic [2:0] id);
    logic [63:0] sh;
    sh = prios >> ({3'b000, id} << 3);
    return sh[7:0];
  endfunction

  function automatic idx_t next_idx(input idx_t i);
    return (32'(i) == QUEUE_DEPTH - 1) ? '0 : idx_t'(32'(i) + 1);
  endfunction

  function automatic idx_t prev_idx(input idx_t i);
    return (i == '0) ? idx_t'(QUEUE_DEPTH - 1) : idx_t'(32'(i) - 1);
  endfunction

endpackage

// File: hw/rtl/pmdq_ram.sv
// ----------------------------------------------------------------------------
// pmdq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pmdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/priority_message_dispatch_queue.sv
// ----------------------------------------------------------------------------
// priority_message_dispatch_queue: circular message queue, priority dispatch
// A post goes from the input transfer through S_FINISH into the output register.
// A dispatch scans the N live entries, read one per cycle from the store's read
// port, then shifts D older entries one per cycle, then passes through S_FINISH.
// One item in flight; a waiting result does not block the next transfer.
// Reset clears head, tail, count and config registers; the store is not cleared.
// ----------------------------------------------------------------------------
module priority_message_dispatch_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // source_task[3:0], dest_task[6:4], signal_code[14:7],
                                  // parameter_word[30:15], zero[31]
  input  logic        in_tuser,   // command[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_source[3:0], out_dest[6:4], out_signal[14:7],
                                  // out_parameter[30:15], zero[31]
  output logic [2:0]  out_tuser,  // status[2:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  pmdq_pkg::state_t state_r, state_nxt;
  pmdq_pkg::idx_t   head_r, head_nxt, tail_r, tail_nxt;
  pmdq_pkg::cnt_t   count_r, count_nxt;
  logic [7:0]       present_r, handler_r;
  logic [63:0]      prio_r;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  pmdq_pkg::msg_t   out_msg_r, out_msg_nxt;
  logic [2:0]       res_status_r, res_status_nxt;
  pmdq_pkg::msg_t   res_msg_r, res_msg_nxt;

  pmdq_pkg::idx_t   scan_pos_r, scan_pos_nxt;
  pmdq_pkg::cnt_t   scan_left_r, scan_left_nxt;
  logic             found_r, found_nxt;
  pmdq_pkg::idx_t   best_pos_r, best_pos_nxt;
  logic [7:0]       best_prio_r, best_prio_nxt;
  pmdq_pkg::msg_t   best_msg_r, best_msg_nxt;
  pmdq_pkg::idx_t   pos_r, pos_nxt;

  logic             ram_we;
  pmdq_pkg::idx_t   ram_waddr, ram_raddr;
  pmdq_pkg::msg_t   ram_wdata, ram_rdata;
  logic [pmdq_pkg::MSG_W-1:0] ram_rdata_raw;

  pmdq_pkg::msg_t   in_msg;
  logic             hit;
  logic             cfg_wr;

  pmdq_ram #(
    .WIDTH(pmdq_pkg::MSG_W),
    .DEPTH(pmdq_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );

  assign ram_rdata = pmdq_pkg::msg_t'(ram_rdata_raw);

  assign in_msg.src   = in_tdata[3:0];
  assign in_msg.dst   = in_tdata[6:4];
  assign in_msg.sig   = in_tdata[14:7];
  assign in_msg.param = in_tdata[30:15];

  assign in_tready  = (state_r == pmdq_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_msg_r.param, out_msg_r.sig, out_msg_r.dst, out_msg_r.src};

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[4:3])
      pmdq_pkg::REG_PRESENT:  cfg_prdata = {56'd0, present_r};
      pmdq_pkg::REG_HANDLER:  cfg_prdata = {56'd0, handler_r};
      pmdq_pkg::REG_PRIORITY: cfg_prdata = prio_r;
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      handler_r <= '0;
      prio_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:3])
        pmdq_pkg::REG_PRESENT:  present_r <= cfg_pwdata[7:0];
        pmdq_pkg::REG_HANDLER:  handler_r <= cfg_pwdata[7:0];
        pmdq_pkg::REG_PRIORITY: prio_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmdq_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_msg_r    <= out_msg_nxt;
    res_status_r <= res_status_nxt;
    res_msg_r    <= res_msg_nxt;
    scan_pos_r   <= scan_pos_nxt;
    scan_left_r  <= scan_left_nxt;
    found_r      <= found_nxt;
    best_pos_r   <= best_pos_nxt;
    best_prio_r  <= best_prio_nxt;
    best_msg_r   <= best_msg_nxt;
    pos_r        <= pos_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_msg_nxt    = out_msg_r;
    res_status_nxt = res_status_r;
    res_msg_nxt    = res_msg_r;
    scan_pos_nxt   = scan_pos_r;
    scan_left_nxt  = scan_left_r;
    found_nxt      = found_r;
    best_pos_nxt   = best_pos_r;
    best_prio_nxt  = best_prio_r;
    best_msg_nxt   = best_msg_r;
    pos_nxt        = pos_r;
    ram_we         = 1'b0;
    ram_waddr      = tail_r;
    ram_wdata      = in_msg;
    ram_raddr      = head_r;
    hit            = 1'b0;

    unique case (state_r)
      pmdq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          res_msg_nxt = '0;
          if (in_tuser == pmdq_pkg::CMD_POST) begin
            state_nxt = pmdq_pkg::S_FINISH;
            if (!pmdq_pkg::task_bit(present_r, in_msg.dst)) begin
              res_status_nxt = pmdq_pkg::STAT_UNKNOWN;
            end else if (count_r == pmdq_pkg::cnt_t'(pmdq_pkg::QUEUE_DEPTH)) begin
              res_status_nxt = pmdq_pkg::STAT_FULL;
            end else begin
              ram_we         = 1'b1;
              tail_nxt       = pmdq_pkg::next_idx(tail_r);
              count_nxt      = count_r + 1'b1;
              res_status_nxt = pmdq_pkg::STAT_OK;
            end
          end else if (count_r == '0) begin
            res_status_nxt = pmdq_pkg::STAT_EMPTY;
            state_nxt      = pmdq_pkg::S_FINISH;
          end else begin
            ram_raddr     = head_r;
            scan_pos_nxt  = head_r;
            scan_left_nxt = count_r - 1'b1;
            found_nxt     = 1'b0;
            state_nxt     = pmdq_pkg::S_SCAN;
          end
        end
      end

      pmdq_pkg::S_SCAN: begin
        hit = pmdq_pkg::task_bit(present_r, ram_rdata.dst) &&
              (!found_r || (pmdq_pkg::task_prio(prio_r, ram_rdata.dst) > best_prio_r));
        if (hit) begin
          found_nxt     = 1'b1;
          best_pos_nxt  = scan_pos_r;
          best_prio_nxt = pmdq_pkg::task_prio(prio_r, ram_rdata.dst);
          best_msg_nxt  = ram_rdata;
        end
        if (scan_left_r == '0) begin
          if (!found_nxt) begin
            res_status_nxt = pmdq_pkg::STAT_UNKNOWN;
            res_msg_nxt    = '0;
            state_nxt      = pmdq_pkg::S_FINISH;
          end else if (best_pos_nxt == head_r) begin
            head_nxt       = pmdq_pkg::next_idx(head_r);
            count_nxt      = count_r - 1'b1;
            res_status_nxt = pmdq_pkg::task_bit(handler_r, best_msg_nxt.dst) ?
                             pmdq_pkg::STAT_OK : pmdq_pkg::STAT_NO_HANDLER;
            res_msg_nxt    = best_msg_nxt;
            state_nxt      = pmdq_pkg::S_FINISH;
          end else begin
            ram_raddr = pmdq_pkg::prev_idx(best_pos_nxt);
            pos_nxt   = best_pos_nxt;
            state_nxt = pmdq_pkg::S_SHIFT;
          end
        end else begin
          ram_raddr     = pmdq_pkg::next_idx(scan_pos_r);
          scan_pos_nxt  = pmdq_pkg::next_idx(scan_pos_r);
          scan_left_nxt = scan_left_r - 1'b1;
        end
      end

      pmdq_pkg::S_SHIFT: begin
        // move the older neighbor one place toward the tail
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = ram_rdata;
        pos_nxt   = pmdq_pkg::prev_idx(pos_r);
        if (pmdq_pkg::prev_idx(pos_r) == head_r) begin
          head_nxt       = pmdq_pkg::next_idx(head_r);
          count_nxt      = count_r - 1'b1;
          res_status_nxt = pmdq_pkg::task_bit(handler_r, best_msg_r.dst) ?
                           pmdq_pkg::STAT_OK : pmdq_pkg::STAT_NO_HANDLER;
          res_msg_nxt    = best_msg_r;
          state_nxt      = pmdq_pkg::S_FINISH;
        end else begin
          ram_raddr = pmdq_pkg::prev_idx(pmdq_pkg::prev_idx(pos_r));
        end
      end

      pmdq_pkg::S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_msg_nxt    = res_msg_r;
          state_nxt      = pmdq_pkg::S_IDLE;
        end
      end

      default: state_nxt = pmdq_pkg::S_IDLE;
    endcase
  end

endmodule

// File: verif/tb_priority_message_dispatch_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_message_dispatch_queue: self-checking bench for the dispatch queue
// Drives post and dispatch commands over the input stream and reprograms task
// masks and priorities over APB between phases. A scoreboard keeps a shadow
// of the queue, predicts each status and dispatched message, and checks every
// result transfer in order. Random idling on both sides, plus one long
// receiver hold-off, exercise back-pressure.
// ----------------------------------------------------------------------------
module tb_priority_message_dispatch_queue;
  import pmdq_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int SEGMENTS = 9;
  localparam int SEGMENT_ITEMS = 200;

  typedef struct packed {
    logic [2:0] status;
    msg_t       msg;
  } dispatch_result_t;

  class dispatch_scoreboard;
    msg_t             slots[QUEUE_DEPTH];
    int unsigned      head_slot;
    int unsigned      tail_slot;
    int unsigned      live_count;
    logic [7:0]       present_mask;
    logic [7:0]       handler_mask;
    logic [63:0]      prio_table;
    dispatch_result_t awaited[$];
    int unsigned      mismatches;

    function new();
      head_slot = 0;
      tail_slot = 0;
      live_count = 0;
      present_mask = '0;
      handler_mask = '0;
      prio_table = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_PRESENT:  present_mask = value[7:0];
        REG_HANDLER:  handler_mask = value[7:0];
        REG_PRIORITY: prio_table = value;
        default: ;
      endcase
    endfunction

    function bit task_alive(logic [2:0] id);
      return (int'(id) < TASK_SLOTS) && present_mask[id];
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // predict the result of one accepted command and update the shadow queue
    function void note_command(logic cmd, msg_t m);
      dispatch_result_t r;
      int unsigned pos;
      int unsigned best;
      int unsigned prv;
      logic [7:0] best_prio;
      logic [7:0] p;
      bit found;
      msg_t pick;
      r.status = STAT_OK;
      r.msg = '0;
      if (cmd == CMD_POST) begin
        if (!task_alive(m.dst)) begin
          r.status = STAT_UNKNOWN;
        end else if (live_count >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          slots[tail_slot] = m;
          tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
          live_count++;
        end
      end else if (live_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        pos = head_slot;
        best = 0;
        best_prio = '0;
        found = 0;
        for (int i = 0; i < live_count; i++) begin
          if (task_alive(slots[pos].dst)) begin
            p = prio_table[8*slots[pos].dst +: 8];
            if (!found || p > best_prio) begin
              found = 1;
              best = pos;
              best_prio = p;
            end
          end
          pos = (pos + 1) % QUEUE_DEPTH;
        end
        if (!found) begin
          r.status = STAT_UNKNOWN;
        end else begin
          pick = slots[best];
          while (best != head_slot) begin
            prv = (best + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            slots[best] = slots[prv];
            best = prv;
          end
          head_slot = (head_slot + 1) % QUEUE_DEPTH;
          live_count--;
          r.status = handler_mask[pick.dst] ? STAT_OK : STAT_NO_HANDLER;
          r.msg = pick;
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_result(logic [2:0] status, logic [31:0] data);
      dispatch_result_t want;
      msg_t got;
      got = data[MSG_W-1:0];
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d data %h", status, data);
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status || got.src !== want.msg.src || got.dst !== want.msg.dst ||
          got.sig !== want.msg.sig || got.param !== want.msg.param) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status %0d/%0d src %0d/%0d dst %0d/%0d sig %h/%h param %h/%h",
                   want.status, status, want.msg.src, got.src, want.msg.dst, got.dst,
                   want.msg.sig, got.sig, want.msg.param, got.param);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        pressure_req = 1'b0;

  dispatch_scoreboard board = new();

  priority_message_dispatch_queue dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_command(logic cmd, msg_t m);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {1'b0, m};
    do @(posedge clk); while (!in_tready);
    board.note_command(cmd, m);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_queue();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  // receive side: check each result transfer, apply idling and the long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    logic pressure_seen;
    hold_left = 0;
    pressure_seen = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        board.check_result(out_tuser, out_tdata);
      if (pressure_req != pressure_seen) begin
        pressure_seen = pressure_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    msg_t m;
    logic cmd;
    int unsigned post_pct;
    logic [7:0] present;
    logic [7:0] handler;
    logic [63:0] prios;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    post_pct = 50;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue, absent task, fill, full, priority ties, handlers
    m = '0;
    send_command(CMD_DISPATCH, m);
    m.src = 4'd8;
    m.dst = 3'd3;
    m.sig = 8'hFF;
    m.param = 16'hFFFF;
    send_command(CMD_POST, m);
    drain_queue();
    cfg_write(REG_PRESENT, 64'hFE);
    cfg_write(REG_HANDLER, 64'h55);
    cfg_write(REG_PRIORITY, 64'h007F_8001_FFFF_FE00);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      m.src = 4'(i);
      m.dst = 3'(1 + i % 7);
      m.sig = (i % 2) ? 8'hFF : 8'(i * 17);
      m.param = (i % 2) ? 16'h0000 : (16'hFFFF ^ 16'(i));
      send_command(CMD_POST, m);
    end
    m.dst = 3'd5;
    send_command(CMD_POST, m);
    m.dst = 3'd0;
    send_command(CMD_POST, m);
    repeat (3) send_command(CMD_DISPATCH, m);
    drain_queue();
    cfg_write(REG_PRESENT, 64'h01);
    send_command(CMD_DISPATCH, m);

    // random phases, each with its own task setup
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_queue();
      send_idle_pct = (seg < 3) ? 29 : (seg < 6) ? 70 : 0;
      recv_idle_pct = (seg < 3) ? 70 : (seg < 6) ? 29 : 0;
      present = 8'($urandom_range(255));
      handler = 8'($urandom_range(255));
      for (int b = 0; b < 8; b++)
        prios[8*b +: 8] = (seg % 2) ? 8'($urandom_range(3)) : 8'($urandom);
      case (seg)
        0: begin
          present = 8'hFF;
          handler = 8'hFF;
          prios = '0;
        end
        1: begin
          present = 8'hFF;
          handler = 8'h00;
          prios = '1;
        end
        2: present = 8'h80;
        default: ;
      endcase
      cfg_write(REG_PRESENT, {56'd0, present});
      cfg_write(REG_HANDLER, {56'd0, handler});
      cfg_write(REG_PRIORITY, prios);
      if (seg == 6)
        pressure_req = ~pressure_req;
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (n % 50 == 0)
          post_pct = 20 + 30 * $urandom_range(2);
        cmd = ($urandom_range(99) < post_pct) ? CMD_POST : CMD_DISPATCH;
        m.src = 4'($urandom_range(15));
        m.sig = 8'($urandom);
        m.param = 16'($urandom);
        m.dst = 3'($urandom_range(7));
        if (cmd == CMD_POST && board.present_mask != 0 && $urandom_range(9) != 0) begin
          while (!board.present_mask[m.dst])
            m.dst = 3'($urandom_range(7));
        end
        send_command(cmd, m);
      end
    end

    drain_queue();
    if (board.mismatches == 0 && board.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/pmdq_pkg.sv
hw/rtl/pmdq_ram.sv
hw/rtl/priority_message_dispatch_queue.sv
verif/tb_priority_message_dispatch_queue.sv
